// ===== sv/stroke_rate_detector_assert.svh =====
// ----------------------------------------------------------------------------
// stroke rate detector assertion macros
// concurrent checks on clk, held off while rst is high
// ----------------------------------------------------------------------------
`ifndef STROKE_RATE_DETECTOR_ASSERT_SVH
`define STROKE_RATE_DETECTOR_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge
`define SRD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SRD_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SRD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SRD_ASSERT(lbl, cond, msg)
`define SRD_IMPLIES(lbl, ante, cons, msg)
`define SRD_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// shared widths, register codes and reset values of the stroke rate detector
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int RatioW   = 7;
  localparam int ThreshW  = 15;
  localparam int SampleW  = 16;
  localparam int MsW      = 16;
  localparam int RateW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  // elapsed-time queue between front and divider
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef logic [MsW-1:0] ms_t;

  localparam ms_t MsPerMinute = 16'd60000;
  localparam ms_t MsMax       = 16'hffff;

  localparam logic [RatioW-1:0]  RatioReset     = 7'd4;
  localparam logic [ThreshW-1:0] ThresholdReset = 15'd3277;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRatio     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegThreshold = 1'b1;

  // word kinds
  localparam logic KindTick   = 1'b0;
  localparam logic KindSample = 1'b1;

endpackage

// ===== sv/stroke_rate_detector.sv =====
// ----------------------------------------------------------------------------
// stroke_rate_detector
// counts strokes from gyro samples and ms ticks, reports the low 8 bits of 60000 / elapsed ms
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         push / full        kind, sample
//  result    out        empty / pop        stroke_rate, elapsed_ms
//  config    in         cfg_we             cfg_index, cfg_data
//
//  a tick or a sample is taken by the front while push is high and full low
//  in the divider a stroke word gets one load, 16 quotient steps and one
//  write into the result register, which waits while an unread result is held
//  up to two stroke words wait between front and divider; full is high
//  while that queue holds two
//  rst is synchronous: ratio 4, threshold 3277, counters and sign cleared
// ----------------------------------------------------------------------------
module stroke_rate_detector (
  input  logic                               clk,
  input  logic                               rst,
  // input word
  input  logic                               push,
  output logic                               full,
  input  logic                               kind,
  input  logic signed [srd_pkg::SampleW-1:0] sample,
  // result word
  output logic                               empty,
  input  logic                               pop,
  output logic [srd_pkg::RateW-1:0]          stroke_rate,
  output logic [srd_pkg::MsW-1:0]            elapsed_ms,
  // config writes
  input  logic                               cfg_we,
  input  logic [srd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [srd_pkg::CfgDataW-1:0]       cfg_data
);

  // front to queue
  logic         f_push;
  srd_pkg::ms_t f_data;
  // queue to divider
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  srd_pkg::ms_t q_data;

  // input is held off whenever a stroke could find the queue full
  assign full = q_full;

  // front: classifies ticks and samples, emits clamped elapsed time per stroke
  srd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .kind      (kind),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_data    (f_data)
  );

  // decoupling queue
  srd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  // back: serial divide and result register
  srd_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .stroke_rate (stroke_rate),
    .elapsed_ms  (elapsed_ms)
  );

endmodule

// ===== sv/srd_front.sv =====
// ----------------------------------------------------------------------------
// srd_front
// config registers, ms counter, downsampling and stroke classification
// ----------------------------------------------------------------------------
module srd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic                           kind,
  input  logic signed [srd_pkg::SampleW-1:0] sample,
  input  logic                           cfg_we,
  input  logic [srd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [srd_pkg::CfgDataW-1:0]   cfg_data,
  output logic                           q_push,
  output srd_pkg::ms_t                   q_data
);

  logic [srd_pkg::RatioW-1:0]  ratio;
  logic [srd_pkg::ThreshW-1:0] threshold;
  logic [srd_pkg::RatioW-1:0]  phase;
  logic                        prev_neg;
  srd_pkg::ms_t                ms;

  logic                        accept;
  logic [srd_pkg::RatioW-1:0]  ratio_eff;
  logic [srd_pkg::RatioW:0]    phase_inc;
  logic [srd_pkg::RatioW-1:0]  phase_next;
  logic                        keep;
  logic [srd_pkg::SampleW:0]   mag;
  logic                        cur_neg;
  logic                        stroke;

  assign accept    = push && !full;
  assign ratio_eff = (ratio == '0) ? srd_pkg::RatioW'(1) : ratio;
  assign phase_inc = {1'b0, phase} + (srd_pkg::RatioW+1)'(1);
  assign phase_next = (phase_inc >= {1'b0, ratio_eff}) ? '0
                                                       : phase_inc[srd_pkg::RatioW-1:0];
  assign keep    = (phase == '0);
  assign cur_neg = sample[srd_pkg::SampleW-1];
  assign mag     = cur_neg ? ((srd_pkg::SampleW+1)'(0) - {sample[srd_pkg::SampleW-1], sample})
                           : {1'b0, sample};
  assign stroke  = (mag >= {2'b00, threshold}) && (cur_neg != prev_neg);

  assign q_push = accept && (kind == srd_pkg::KindSample) && keep && stroke;
  assign q_data = (ms == '0) ? srd_pkg::MsW'(1) : ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio     <= srd_pkg::RatioReset;
      threshold <= srd_pkg::ThresholdReset;
      phase     <= '0;
      prev_neg  <= 1'b0;
      ms        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          srd_pkg::RegRatio:     ratio     <= cfg_data[srd_pkg::RatioW-1:0];
          srd_pkg::RegThreshold: threshold <= cfg_data[srd_pkg::ThreshW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (kind == srd_pkg::KindTick) begin
          if (ms != srd_pkg::MsMax) begin
            ms <= ms + srd_pkg::MsW'(1);
          end
        end else begin
          phase <= phase_next;
          if (keep) begin
            prev_neg <= cur_neg;
            if (stroke) begin
              ms <= '0;
            end
          end
        end
      end
    end
  end

endmodule

// ===== sv/srd_queue.sv =====
// ----------------------------------------------------------------------------
// srd_queue
// short fifo of elapsed times between the front and the divider
// ----------------------------------------------------------------------------
`include "stroke_rate_detector_assert.svh"

module srd_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  srd_pkg::ms_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output srd_pkg::ms_t pop_data
);

  srd_pkg::ms_t              slots [srd_pkg::QDepth];
  logic [srd_pkg::QPtrW-1:0] wr_ptr;
  logic [srd_pkg::QPtrW-1:0] rd_ptr;
  logic [srd_pkg::QCntW-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign full     = (count == srd_pkg::QCntW'(srd_pkg::QDepth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == srd_pkg::QPtrW'(srd_pkg::QDepth - 1)) ? '0
                                                                   : wr_ptr + srd_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == srd_pkg::QPtrW'(srd_pkg::QDepth - 1)) ? '0
                                                                   : rd_ptr + srd_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + srd_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - srd_pkg::QCntW'(1);
      end
    end
  end

  `SRD_ASSERT(a_q_count_range, count <= srd_pkg::QCntW'(srd_pkg::QDepth), "queue overfilled")
  `SRD_NEXT(a_q_fill, do_push && !do_pop, !empty, "pushed word lost")

endmodule

// ===== sv/srd_divider.sv =====
// ----------------------------------------------------------------------------
// srd_divider
// restoring divider for 60000 / elapsed, one quotient bit per cycle,
// with the result word register
// ----------------------------------------------------------------------------
`include "stroke_rate_detector_assert.svh"

module srd_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  srd_pkg::ms_t               q_data,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [srd_pkg::RateW-1:0]  stroke_rate,
  output srd_pkg::ms_t               elapsed_ms
);

  localparam int QuotW = srd_pkg::MsW;
  localparam int CntW  = $clog2(QuotW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t              state;
  srd_pkg::ms_t        divisor;
  srd_pkg::ms_t        rem;
  logic [QuotW-1:0]    quot;
  logic [CntW-1:0]     step;
  logic                out_valid;

  logic [srd_pkg::MsW:0] trial;
  logic                  fits;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;
  assign trial = {rem, quot[QuotW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // in done the result register is refilled below, so only clear elsewhere
      if (pop && out_valid && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            divisor <= q_data;
            rem     <= '0;
            quot    <= srd_pkg::MsPerMinute;
            step    <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          rem  <= fits ? srd_pkg::MsW'(trial - {1'b0, divisor}) : trial[srd_pkg::MsW-1:0];
          quot <= {quot[QuotW-2:0], fits};
          step <= step + CntW'(1);
          if (step == CntW'(QuotW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            out_valid   <= 1'b1;
            stroke_rate <= quot[srd_pkg::RateW-1:0];
            elapsed_ms  <= divisor;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRD_IMPLIES(a_div_nonzero, state == S_RUN, divisor != '0, "divide by zero")
  `SRD_IMPLIES(a_div_rem, state == S_RUN, rem < divisor, "remainder not reduced")
  `SRD_NEXT(a_done_hold, state == S_DONE && out_valid && !pop, state == S_DONE,
            "result overwritten")

endmodule
